/* rtl/ses_pkg.sv */
// ----------------------------------------------------------------------------
// ses_pkg
// shared constants and types of the schedule entry sorter
// ----------------------------------------------------------------------------
package ses_pkg;
	localparam int MAX_ENTRIES = 64;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int DAY_W = 7;
	localparam int TIME_W = 16;
	localparam int TAG_W = 16;
	localparam int REC_W = DAY_W + TIME_W + TAG_W;
	localparam int IN_TDATA_W = 40;
	localparam int OUT_TDATA_W = 40;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [TIME_W-1:0] tim;
		logic [DAY_W-1:0] days;
	} rec_t;

	// true when a must strictly precede b
	function automatic logic precedes(rec_t a, rec_t b);
		logic [DAY_W-1:0] ra, rb;
		for (int i = 0; i < DAY_W; i++) begin
			ra[DAY_W-1-i] = a.days[i];
			rb[DAY_W-1-i] = b.days[i];
		end
		if (ra != rb) return ra > rb;
		return a.tim < b.tim;
	endfunction
endpackage

/* rtl/schedule_entry_sorter.sv */
// ----------------------------------------------------------------------------
// schedule_entry_sorter
// collects records until one marked last, then emits them in stable order
// ----------------------------------------------------------------------------
// Records load at one item per cycle into a record ram. The item marked last
// starts an insertion sort over an index ram: each record i is read, then
// the sorted list is walked backward entry by entry (index read, then
// record read), shifting larger entries up. The sorted run is then
// emitted item by item, each one read from the rams only after the
// previous one is taken; input is held off from the last item until the
// final result is taken.
module schedule_entry_sorter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// day_mask[6:0], arrival_time[22:7], record_tag[38:23], zero fill
	input  logic [ses_pkg::IN_TDATA_W-1:0] s_tdata,
	input  logic                      s_tlast,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// sorted_days[6:0], sorted_time[22:7], sorted_tag[38:23], zero fill
	output logic [ses_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                      m_tlast,
	// overflowed
	output logic                      m_tuser
);
	import ses_pkg::*;

	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_RCUR = 3'd1;
	localparam logic [2:0] ST_RIDX = 3'd2;
	localparam logic [2:0] ST_CMP  = 3'd3;
	localparam logic [2:0] ST_ORD  = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;
	localparam logic [2:0] ST_WAIT = 3'd6;
	localparam logic [2:0] ST_SHOW = 3'd7;

	logic [2:0] state_q;
	logic [CNT_W-1:0] count_q, i_q, j_q, k_q;
	logic ovf_q;
	rec_t cur_q;

	logic rec_we, ord_we;
	logic [IDX_W-1:0] rec_wa, rec_ra, ord_wa, ord_ra;
	rec_t rec_wd, rec_rd;
	logic [IDX_W-1:0] ord_wd, ord_rd, idx_q;

	ses_ram #(.WIDTH(REC_W), .DEPTH(MAX_ENTRIES)) u_rec (
		.clk(clk), .we(rec_we), .waddr(rec_wa), .wdata(rec_wd),
		.raddr(rec_ra), .rdata(rec_rd)
	);
	ses_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_ord (
		.clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd),
		.raddr(ord_ra), .rdata(ord_rd)
	);

	logic s_acc;
	assign s_tready = (state_q == ST_LOAD);
	assign s_acc = s_tvalid && s_tready;
	logic [CNT_W-1:0] jm1;
	logic [CNT_W-1:0] jm2;
	assign jm1 = j_q - CNT_W'(1);
	assign jm2 = j_q - CNT_W'(2);

	always_comb begin
		rec_we = 1'b0;
		rec_wa = count_q[IDX_W-1:0];
		rec_wd = rec_t'(s_tdata[REC_W-1:0]);
		rec_ra = i_q[IDX_W-1:0];
		ord_we = 1'b0;
		ord_wa = j_q[IDX_W-1:0];
		ord_wd = idx_q;
		ord_ra = jm1[IDX_W-1:0];
		case (state_q)
			ST_LOAD: rec_we = s_acc && (count_q < CNT_W'(MAX_ENTRIES));
			ST_RIDX: ord_ra = jm1[IDX_W-1:0];
			ST_CMP:  rec_ra = ord_rd;
			ST_ORD: begin
				// next entry below the one being shifted
				ord_ra = jm2[IDX_W-1:0];
				if (j_q != '0 && precedes(cur_q, rec_rd)) begin
					ord_we = 1'b1;
					ord_wd = idx_q;
				end else begin
					ord_we = 1'b1;
					ord_wd = i_q[IDX_W-1:0];
				end
			end
			ST_EMIT: ord_ra = k_q[IDX_W-1:0];
			ST_WAIT: rec_ra = ord_rd;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			ovf_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			cur_q <= '0;
			idx_q <= '0;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
			m_tlast <= 1'b0;
			m_tuser <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (s_acc) begin
						if (count_q < CNT_W'(MAX_ENTRIES)) count_q <= count_q + CNT_W'(1);
						else ovf_q <= 1'b1;
						if (s_tlast) begin
							i_q <= '0;
							state_q <= ST_RCUR;
						end
					end
				end
				ST_RCUR: begin
					if (i_q == count_q) begin
						k_q <= '0;
						state_q <= (count_q == '0) ? ST_LOAD : ST_EMIT;
						ovf_q <= (count_q == '0) ? 1'b0 : ovf_q;
					end else begin
						j_q <= i_q;
						state_q <= ST_RIDX;
					end
				end
				ST_RIDX: begin
					cur_q <= rec_rd;
					state_q <= (j_q == '0) ? ST_ORD : ST_CMP;
				end
				ST_CMP: begin
					idx_q <= ord_rd;
					state_q <= ST_ORD;
				end
				ST_ORD: begin
					if (j_q != '0 && precedes(cur_q, rec_rd)) begin
						j_q <= jm1;
						state_q <= (jm1 == '0) ? ST_ORD : ST_CMP;
					end else begin
						i_q <= i_q + CNT_W'(1);
						state_q <= ST_RCUR;
					end
				end
				ST_EMIT: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b0;
						if (m_tvalid && m_tlast) begin
							count_q <= '0;
							ovf_q <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_WAIT;
						end
					end
				end
				ST_WAIT: state_q <= ST_SHOW;
				ST_SHOW: begin
					m_tvalid <= 1'b1;
					m_tdata <= {{(OUT_TDATA_W-REC_W){1'b0}}, rec_rd};
					m_tlast <= (k_q + CNT_W'(1) == count_q);
					m_tuser <= ovf_q;
					k_q <= k_q + CNT_W'(1);
					state_q <= ST_EMIT;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule

/* rtl/ses_ram.sv */
// ----------------------------------------------------------------------------
// ses_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module ses_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* tb/schedule_entry_sorter_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// schedule_entry_sorter_tb
// drives record sets into the sorter and checks each sorted run it emits
// ----------------------------------------------------------------------------
// Record sets are sent over the input stream and closed by an item marked
// last. A model in the testbench keeps its own copy of the set, sorts it in
// stable order on weekday bits from day 0 up and then on arrival time, and
// queues the expected run. A checker compares every output item with the
// oldest expected one. Sets cover sizes from one record up to the store
// size, overflow in which the last item is dropped but still ends the set,
// a long receiver stall and random gaps on both sides.
// ----------------------------------------------------------------------------
module schedule_entry_sorter_tb;
	import ses_pkg::*;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [TIME_W-1:0] tim;
		logic [DAY_W-1:0]  days;
		logic              last;
		logic              ovf;
	} sorted_rec_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic m_tlast;
	logic m_tuser;

	sorted_rec_t expected_runs[$];
	rec_t set_recs[$];
	logic set_ovf;
	int errors;
	int cycles;
	int send_idle_pct;
	int recv_idle_pct;
	int recv_hold;

	schedule_entry_sorter u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
	endtask

	function automatic logic goes_first(rec_t a, rec_t b);
		for (int d = 0; d < DAY_W; d++) begin
			if (a.days[d] != b.days[d]) return a.days[d];
		end
		return a.tim < b.tim;
	endfunction

	// accept one record into the model set; on last, queue the sorted run
	task automatic model_record(input rec_t r, input logic last);
		rec_t sorted[$];
		int j;
		sorted_rec_t e;
		if (set_recs.size() < MAX_ENTRIES) set_recs.push_back(r);
		else set_ovf = 1'b1;
		if (!last) return;
		foreach (set_recs[i]) begin
			j = sorted.size();
			while (j > 0 && goes_first(set_recs[i], sorted[j-1])) j--;
			sorted.insert(j, set_recs[i]);
		end
		foreach (sorted[i]) begin
			e.tag = sorted[i].tag;
			e.tim = sorted[i].tim;
			e.days = sorted[i].days;
			e.last = (i == sorted.size() - 1);
			e.ovf = set_ovf;
			expected_runs.push_back(e);
		end
		set_recs.delete();
		set_ovf = 1'b0;
	endtask

	task automatic send_record(input rec_t r, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_TDATA_W-REC_W){1'b0}}, r};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		model_record(r, last);
	endtask

	function automatic rec_t rand_rec(input int mode);
		rec_t r;
		r.tag = $urandom;
		case (mode)
			0: begin
				r.days = $urandom;
				r.tim = $urandom;
			end
			default: begin
				// few distinct keys so ties and stability get exercised
				r.days = $urandom_range(3) == 0 ? 7'h7f : 7'(1 << $urandom_range(6));
				r.tim = $urandom_range(3);
			end
		endcase
		return r;
	endfunction

	task automatic send_set(input int n, input int mode);
		for (int i = 0; i < n; i++) send_record(rand_rec(mode), i == n - 1);
	endtask

	task automatic test_extremes();
		rec_t r;
		r = '0;
		send_record(r, 1'b1);
		r = '1;
		send_record(r, 1'b0);
		r = '0;
		send_record(r, 1'b0);
		r.days = 7'h01; r.tim = 16'hffff; r.tag = 16'h5555;
		send_record(r, 1'b0);
		r.days = 7'h40; r.tim = 16'h0000; r.tag = 16'haaaa;
		send_record(r, 1'b0);
		r.days = 7'h01; r.tim = 16'hffff; r.tag = 16'h1234;
		send_record(r, 1'b0);
		r.days = 7'h2a; r.tim = 16'h8000; r.tag = 16'hffff;
		send_record(r, 1'b1);
	endtask

	task automatic test_ties();
		send_set(12, 1);
	endtask

	task automatic test_full_store();
		send_set(MAX_ENTRIES, 0);
	endtask

	task automatic test_overflow();
		send_set(MAX_ENTRIES + 3, 1);
		// last item dropped but still ends the set
		send_set(MAX_ENTRIES + 1, 0);
	endtask

	task automatic test_stall();
		recv_hold = 300;
		send_set(20, 0);
		send_set(5, 1);
	endtask

	task automatic test_random();
		int sent;
		int n;
		sent = 0;
		while (sent < 170) begin
			send_idle_pct = (sent > 60 && sent < 120) ? 0 : 24;
			recv_idle_pct = send_idle_pct;
			n = $urandom_range(9) == 0 ? $urandom_range(MAX_ENTRIES + 2, 30)
			                             : $urandom_range(10, 1);
			send_set(n, $urandom_range(1));
			sent += n;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_hold <= 0;
		end else if (recv_hold > 0) begin
			m_tready <= 1'b0;
			recv_hold <= recv_hold - 1;
		end else begin
			m_tready <= $urandom_range(99) >= recv_idle_pct;
		end
	end

	always @(posedge clk) begin
		sorted_rec_t e;
		if (arst_n) begin
			cycles <= cycles + 1;
			if (m_tvalid && m_tready) begin
				if (expected_runs.size() == 0) begin
					report("unexpected item", 64'(m_tdata), 64'd0);
				end else begin
					e = expected_runs.pop_front();
					if (m_tdata[DAY_W-1:0] !== e.days)
						report("days", 64'(m_tdata[DAY_W-1:0]), 64'(e.days));
					if (m_tdata[DAY_W+TIME_W-1:DAY_W] !== e.tim)
						report("time", 64'(m_tdata[DAY_W+TIME_W-1:DAY_W]), 64'(e.tim));
					if (m_tdata[REC_W-1:DAY_W+TIME_W] !== e.tag)
						report("tag", 64'(m_tdata[REC_W-1:DAY_W+TIME_W]), 64'(e.tag));
					if (m_tlast !== e.last) report("last", 64'(m_tlast), 64'(e.last));
					if (m_tuser !== e.ovf) report("overflowed", 64'(m_tuser), 64'(e.ovf));
				end
			end
			if (cycles > 2000000) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		set_ovf = 1'b0;
		send_idle_pct = 24;
		recv_idle_pct = 24;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_ties();
		test_full_store();
		test_overflow();
		test_stall();
		test_random();
		s_tvalid <= 1'b0;
		while (expected_runs.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_runs.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
